// ----- hw/rtl/rgbst_pkg.sv -----
package rgbst_pkg;

    localparam int CHAN_W = 8;
    localparam int COEF_W = 10;
    localparam int WEIGHT_W = 9;
    localparam int PIXEL_W = 16;
    localparam int NUM_CHAN = 3;

    // Products of an 8-bit channel and a Q0.10 coefficient, and their sum of three
    localparam int PROD_W = CHAN_W + COEF_W;
    localparam int SUM_W = PROD_W + 1;
    // Products of an 8-bit channel and a Q1.8 weight, and their sum of two
    localparam int BPROD_W = CHAN_W + WEIGHT_W;

    localparam logic [WEIGHT_W-1:0] FULL_WEIGHT = 9'd256;
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    // Channel order inside a colour: red, green, blue
    localparam int CH_R = 0;
    localparam int CH_G = 1;
    localparam int CH_B = 2;

    typedef logic [CHAN_W-1:0] t_chan;
    typedef logic [COEF_W-1:0] t_coef;
    typedef logic [WEIGHT_W-1:0] t_weight;
    typedef logic [PIXEL_W-1:0] t_pixel;
    typedef t_chan [0:NUM_CHAN-1] t_rgb;

    // Sepia matrix in Q0.10, row per output channel, column per input channel
    localparam t_coef SEPIA_COEF [NUM_CHAN][NUM_CHAN] = '{
        '{10'd402, 10'd787, 10'd194},
        '{10'd357, 10'd702, 10'd172},
        '{10'd279, 10'd547, 10'd134}
    };

endpackage

// ----- hw/rtl/rgbst_matrix.sv -----
module rgbst_matrix (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  rgbst_pkg::t_rgb    i_rgb,
    output logic               o_valid,
    input  logic               i_ready,
    output rgbst_pkg::t_rgb    o_orig,
    output rgbst_pkg::t_rgb    o_sepia
);

    logic [rgbst_pkg::PROD_W-1:0] r_prod [rgbst_pkg::NUM_CHAN][rgbst_pkg::NUM_CHAN];
    logic [rgbst_pkg::PROD_W-1:0] n_prod [rgbst_pkg::NUM_CHAN][rgbst_pkg::NUM_CHAN];
    rgbst_pkg::t_rgb r_orig1;
    rgbst_pkg::t_rgb r_orig2;
    rgbst_pkg::t_rgb r_sepia;
    rgbst_pkg::t_rgb n_sepia;
    logic r_v1;
    logic r_v2;
    logic w_rdy1;
    logic w_rdy2;

    assign w_rdy2  = !r_v2 || i_ready;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v2;
    assign o_orig  = r_orig2;
    assign o_sepia = r_sepia;

    always_comb begin
        for (int o = 0; o < rgbst_pkg::NUM_CHAN; o++) begin
            for (int c = 0; c < rgbst_pkg::NUM_CHAN; c++) begin
                n_prod[o][c] = rgbst_pkg::PROD_W'(i_rgb[c]) *
                               rgbst_pkg::PROD_W'(rgbst_pkg::SEPIA_COEF[o][c]);
            end
        end
    end

    // Sum the three products, drop ten fraction bits, clip at full scale
    always_comb begin
        logic [rgbst_pkg::SUM_W-1:0] sum;
        logic [rgbst_pkg::SUM_W-11:0] whole;
        for (int o = 0; o < rgbst_pkg::NUM_CHAN; o++) begin
            sum = rgbst_pkg::SUM_W'(r_prod[o][rgbst_pkg::CH_R]) +
                  rgbst_pkg::SUM_W'(r_prod[o][rgbst_pkg::CH_G]) +
                  rgbst_pkg::SUM_W'(r_prod[o][rgbst_pkg::CH_B]);
            whole = sum[rgbst_pkg::SUM_W-1:10];
            n_sepia[o] = whole[rgbst_pkg::SUM_W-11] ? rgbst_pkg::CHAN_MAX
                                                    : whole[rgbst_pkg::CHAN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_prod  <= n_prod;
            r_orig1 <= i_rgb;
        end
        if (w_rdy2) begin
            r_sepia <= n_sepia;
            r_orig2 <= r_orig1;
        end
    end

endmodule

// ----- hw/rtl/rgbst_blend.sv -----
module rgbst_blend (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rgbst_pkg::t_weight  i_tint,
    input  logic                i_valid,
    output logic                o_ready,
    input  rgbst_pkg::t_rgb     i_orig,
    input  rgbst_pkg::t_rgb     i_sepia,
    output logic                o_valid,
    input  logic                i_ready,
    output rgbst_pkg::t_pixel   o_pixel
);

    logic [rgbst_pkg::BPROD_W-1:0] r_po [rgbst_pkg::NUM_CHAN];
    logic [rgbst_pkg::BPROD_W-1:0] r_ps [rgbst_pkg::NUM_CHAN];
    logic [rgbst_pkg::BPROD_W-1:0] n_po [rgbst_pkg::NUM_CHAN];
    logic [rgbst_pkg::BPROD_W-1:0] n_ps [rgbst_pkg::NUM_CHAN];
    rgbst_pkg::t_weight w_keep;
    rgbst_pkg::t_rgb    w_mix;
    rgbst_pkg::t_pixel  r_pixel;
    logic r_v3;
    logic r_v4;
    logic w_rdy3;
    logic w_rdy4;

    assign w_rdy4  = !r_v4 || i_ready;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign o_ready = w_rdy3;
    assign o_valid = r_v4;
    assign o_pixel = r_pixel;

    assign w_keep = rgbst_pkg::FULL_WEIGHT - i_tint;

    always_comb begin
        for (int c = 0; c < rgbst_pkg::NUM_CHAN; c++) begin
            n_po[c] = rgbst_pkg::BPROD_W'(i_orig[c]) * rgbst_pkg::BPROD_W'(w_keep);
            n_ps[c] = rgbst_pkg::BPROD_W'(i_sepia[c]) * rgbst_pkg::BPROD_W'(i_tint);
        end
    end

    // Weights sum to 256, so the blended sum never exceeds 16 bits
    always_comb begin
        logic [rgbst_pkg::BPROD_W-1:0] sum;
        for (int c = 0; c < rgbst_pkg::NUM_CHAN; c++) begin
            sum = r_po[c] + r_ps[c];
            w_mix[c] = sum[15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy3) r_v3 <= i_valid;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_po <= n_po;
            r_ps <= n_ps;
        end
        if (w_rdy4) begin
            r_pixel <= {w_mix[rgbst_pkg::CH_R][7:3],
                        w_mix[rgbst_pkg::CH_G][7:2],
                        w_mix[rgbst_pkg::CH_B][7:3]};
        end
    end

endmodule

// ----- hw/rtl/rgb565_sepia_tint_core.sv -----
// Sepia tint for an RGB565 pixel stream. Each pixel is widened to 8-bit
// channels, passed through the sepia matrix (Q0.10 coefficients, clipped at
// 255), blended with the original by tint strength t in Q1.8 and repacked to
// RGB565. Writes above 256 to the strength register act as 256; 0 returns
// every pixel unchanged. One pixel is taken per clock while o_ready is high;
// a pixel passes through the four-stage pipeline (matrix products, matrix
// sums, blend products, blend sum and repack) and leaves from the last stage.
// A stall on the output fills empty stages first and loses nothing. Change
// the strength only while no transaction is in flight.
module rgb565_sepia_tint_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_pixel_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_pixel_out
);

    rgbst_pkg::t_weight r_tint;
    rgbst_pkg::t_rgb    w_in_rgb;
    rgbst_pkg::t_rgb    w_orig;
    rgbst_pkg::t_rgb    w_sepia;
    logic               w_mid_valid;
    logic               w_mid_ready;

    // Hold the strength clipped to full sepia
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tint <= '0;
        end else if (i_cfg_we) begin
            r_tint <= (i_cfg_wdata > rgbst_pkg::FULL_WEIGHT) ? rgbst_pkg::FULL_WEIGHT
                                                             : i_cfg_wdata;
        end
    end

    assign w_in_rgb[rgbst_pkg::CH_R] = {i_pixel_in[15:11], 3'b000};
    assign w_in_rgb[rgbst_pkg::CH_G] = {i_pixel_in[10:5], 2'b00};
    assign w_in_rgb[rgbst_pkg::CH_B] = {i_pixel_in[4:0], 3'b000};

    rgbst_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_rgb   (w_in_rgb),
        .o_valid (w_mid_valid),
        .i_ready (w_mid_ready),
        .o_orig  (w_orig),
        .o_sepia (w_sepia)
    );

    rgbst_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tint  (r_tint),
        .i_valid (w_mid_valid),
        .o_ready (w_mid_ready),
        .i_orig  (w_orig),
        .i_sepia (w_sepia),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_pixel (o_pixel_out)
    );

endmodule

// ----- verif/tb_rgb565_sepia_tint_core.sv -----
`timescale 1ns / 100ps

module tb_rgb565_sepia_tint_core;
    import rgbst_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASE_ITEMS = 210;
    localparam int NUM_PHASES = 8;
    localparam int NUM_ROWS = 26;

    // Sepia rows in Q0.10, one per output channel
    localparam int unsigned MIX_R [3] = '{402, 787, 194};
    localparam int unsigned MIX_G [3] = '{357, 702, 172};
    localparam int unsigned MIX_B [3] = '{279, 547, 134};

    typedef struct packed {
        logic    set_w;
        t_weight strength;
        t_pixel  pixel;
        logic    fixed;
        t_pixel  want;
    } t_dir_row;

    logic    i_clk;
    logic    i_rst_n;
    logic    i_cfg_we;
    t_weight i_cfg_wdata;
    logic    i_valid;
    logic    o_ready;
    t_pixel  i_pixel_in;
    logic    o_valid;
    logic    i_ready;
    t_pixel  o_pixel_out;

    t_pixel   tinted_q [$];
    t_weight  cur_strength;
    int       mismatches;
    int       quiet_cycles;
    int       tx_idle_pct;
    int       rx_stall_pct;
    bit       rx_hold_req;
    t_dir_row dir_rows [0:NUM_ROWS-1];

    rgb565_sepia_tint_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_pixel_in  (i_pixel_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pixel_out (o_pixel_out)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int unsigned sepia_mix(int unsigned r, int unsigned g, int unsigned b,
                                              int unsigned cr, int unsigned cg,
                                              int unsigned cb);
        int unsigned s;
        s = (r * cr + g * cg + b * cb) >> 10;
        return (s > 255) ? 255 : s;
    endfunction

    function automatic int unsigned blend(int unsigned orig, int unsigned sep, int unsigned w);
        return (orig * (256 - w) + sep * w) >> 8;
    endfunction

    function automatic t_pixel sepia_tint(t_pixel px, t_weight strength);
        int unsigned w, r, g, b, sr, sg, sb, nr, ng, nb;
        // anything above full weight acts as full sepia
        w = (strength > FULL_WEIGHT) ? FULL_WEIGHT : strength;
        if (w == 0) begin
            return px;
        end
        r = {px[15:11], 3'b000};
        g = {px[10:5], 2'b00};
        b = {px[4:0], 3'b000};
        sr = sepia_mix(r, g, b, MIX_R[0], MIX_R[1], MIX_R[2]);
        sg = sepia_mix(r, g, b, MIX_G[0], MIX_G[1], MIX_G[2]);
        sb = sepia_mix(r, g, b, MIX_B[0], MIX_B[1], MIX_B[2]);
        nr = blend(r, sr, w);
        ng = blend(g, sg, w);
        nb = blend(b, sb, w);
        return {nr[7:3], ng[7:2], nb[7:3]};
    endfunction

    function automatic t_pixel rand_pixel();
        logic [4:0] r, b;
        logic [5:0] g;
        // one in eight: every channel pinned to its floor or ceiling
        if ($urandom_range(7) == 0) begin
            r = $urandom_range(1) ? 5'h1F : 5'h00;
            g = $urandom_range(1) ? 6'h3F : 6'h00;
            b = $urandom_range(1) ? 5'h1F : 5'h00;
            return {r, g, b};
        end
        return t_pixel'($urandom_range(16'hFFFF));
    endfunction

    function automatic int pick_gap();
        int g;
        g = 0;
        while (g < 40 && $urandom_range(99) < tx_idle_pct) begin
            g++;
        end
        return g;
    endfunction

    task automatic report_mismatch(t_pixel got, t_pixel want);
        $display("%0t: pixel_out mismatch: got %h want %h", $realtime, got, want);
        mismatches++;
    endtask

    // Entered and left at a falling edge.
    task automatic send_pixel(t_pixel px, logic fixed, t_pixel want, int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel_in <= px;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        tinted_q.push_back(fixed ? want : sepia_tint(px, cur_strength));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (tinted_q.size() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic set_strength(t_weight v);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_strength = v;
    endtask

    // Receiver: random back-pressure, plus one long hold-off on request
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                rx_hold_req = 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Check each output transaction against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (tinted_q.size() == 0) begin
                $display("%0t: unexpected pixel_out %h", $realtime, o_pixel_out);
                mismatches++;
            end else begin
                if (o_pixel_out !== tinted_q[0]) begin
                    report_mismatch(o_pixel_out, tinted_q[0]);
                end
                void'(tinted_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_rgb565_sepia_tint_core: errors");
            $finish;
        end
    end

    initial begin
        t_weight phase_w [NUM_PHASES];
        int mode;

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_valid = 1'b0;
        i_pixel_in = '0;
        cur_strength = '0;
        mismatches = 0;
        quiet_cycles = 0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        rx_hold_req = 1'b0;

        // set_w rows write the strength; fixed rows carry a hand-worked result
        dir_rows = '{
            '{1'b0, 9'd0,   16'h0000, 1'b1, 16'h0000},
            '{1'b0, 9'd0,   16'hFFFF, 1'b1, 16'hFFFF},
            '{1'b0, 9'd0,   16'hF800, 1'b1, 16'hF800},
            '{1'b0, 9'd0,   16'h07E0, 1'b1, 16'h07E0},
            '{1'b0, 9'd0,   16'h001F, 1'b1, 16'h001F},
            '{1'b0, 9'd0,   16'hAAAA, 1'b1, 16'hAAAA},
            '{1'b1, 9'd256, 16'h0000, 1'b0, 16'h0000},
            '{1'b0, 9'd0,   16'h0000, 1'b1, 16'h0000},
            '{1'b0, 9'd0,   16'hFFFF, 1'b1, 16'hFFFD},
            '{1'b0, 9'd0,   16'hF800, 1'b1, 16'h62A8},
            '{1'b0, 9'd0,   16'h07E0, 1'b0, 16'h0000},
            '{1'b0, 9'd0,   16'h001F, 1'b0, 16'h0000},
            '{1'b0, 9'd0,   16'h5555, 1'b0, 16'h0000},
            '{1'b1, 9'd511, 16'h0000, 1'b0, 16'h0000},
            '{1'b0, 9'd0,   16'hFFFF, 1'b1, 16'hFFFD},
            '{1'b0, 9'd0,   16'h8410, 1'b0, 16'h0000},
            '{1'b1, 9'd1,   16'h0000, 1'b0, 16'h0000},
            '{1'b0, 9'd0,   16'hFFFF, 1'b0, 16'h0000},
            '{1'b0, 9'd0,   16'h1234, 1'b0, 16'h0000},
            '{1'b1, 9'd128, 16'h0000, 1'b0, 16'h0000},
            '{1'b0, 9'd0,   16'hFFFF, 1'b0, 16'h0000},
            '{1'b0, 9'd0,   16'h0841, 1'b0, 16'h0000},
            '{1'b1, 9'd257, 16'h0000, 1'b0, 16'h0000},
            '{1'b0, 9'd0,   16'hF800, 1'b1, 16'h62A8},
            '{1'b1, 9'd0,   16'h0000, 1'b0, 16'h0000},
            '{1'b0, 9'd0,   16'h1234, 1'b1, 16'h1234}
        };
        phase_w = '{9'd256, 9'd0, 9'd1, 9'd128, 9'd511, 9'd257, 9'd255, 9'd0};
        phase_w[NUM_PHASES-1] = t_weight'($urandom_range(511));

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].set_w) begin
                set_strength(dir_rows[k].strength);
            end else begin
                send_pixel(dir_rows[k].pixel, dir_rows[k].fixed, dir_rows[k].want, 0);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_strength(phase_w[ph]);
            mode = ph % 4;
            tx_idle_pct = (mode == 1) ? 78 : (mode == 3) ? 31 : 0;
            rx_stall_pct = (mode == 2) ? 78 : (mode == 3) ? 31 : 0;
            // hold the receiver off while items keep coming, so the pipe backs up
            if (ph == 2) begin
                rx_hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2) begin
                    wait_drained();
                end
                send_pixel(rand_pixel(), 1'b0, '0, pick_gap());
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_rgb565_sepia_tint_core: clean");
        end else begin
            $display("tb_rgb565_sepia_tint_core: errors");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/rgbst_pkg.sv
hw/rtl/rgbst_matrix.sv
hw/rtl/rgbst_blend.sv
hw/rtl/rgb565_sepia_tint_core.sv
verif/tb_rgb565_sepia_tint_core.sv
